// ===== design/assert_macros.svh =====
// -----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be seen
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== design/gha_pkg.sv =====
// -----------------------------------------------------------------------------
// gha_pkg
// Shared types, constants and helpers of the handle allocator.
// -----------------------------------------------------------------------------
package gha_pkg;

	localparam int MAX_SLOTS = 1024;
	localparam int GEN_W     = 16;
	localparam int SLOT_AW   = $clog2(MAX_SLOTS);
	localparam int IDX_W     = $clog2(MAX_SLOTS + 1);

	typedef enum logic [1:0] {
		OP_ALLOC  = 2'd0,
		OP_CHECK  = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SWEEP
	} state_t;

	typedef struct packed {
		logic             empty;
		logic [IDX_W-1:0] next;
		logic [GEN_W-1:0] gen;
	} slot_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic exec;
		logic sweep;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sweep_go;
		logic sweep_last;
	} stat_t;

	function automatic logic [GEN_W-1:0] bump_gen(input logic [GEN_W-1:0] g);
		logic [GEN_W-1:0] n;
		n = g + GEN_W'(1);
		return (n == '0) ? GEN_W'(1) : n;
	endfunction

endpackage

// ===== design/gha_ram.sv =====
// -----------------------------------------------------------------------------
// gha_ram
// Simple dual-port RAM, one write and one registered read port.
// -----------------------------------------------------------------------------
module gha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/gha_ctrl.sv =====
// -----------------------------------------------------------------------------
// gha_ctrl
// Sequencer: idle, execute state, store sweep for clear.
// -----------------------------------------------------------------------------
module gha_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  gha_pkg::stat_t stat,
	output gha_pkg::cmd_t  cmd,
	output logic           busy
);

	import gha_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = stat.sweep_go ? ST_SWEEP : ST_IDLE;
			end
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/gha_datapath.sv =====
// -----------------------------------------------------------------------------
// gha_datapath
// Handle state registers, slot update logic and result registers.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module gha_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gha_pkg::cmd_t                 cmd,
	output gha_pkg::stat_t                stat,
	input  logic [1:0]                    operation,
	input  logic [gha_pkg::IDX_W-1:0]     handle_index,
	input  logic [gha_pkg::GEN_W-1:0]     handle_generation,
	output logic                          ram_we,
	output logic [gha_pkg::SLOT_AW-1:0]   ram_waddr,
	output gha_pkg::slot_t                ram_wdata,
	output logic                          ram_re,
	output logic [gha_pkg::SLOT_AW-1:0]   ram_raddr,
	input  gha_pkg::slot_t                ram_rdata,
	output logic                          done,
	output logic [gha_pkg::IDX_W-1:0]     result_index,
	output logic [gha_pkg::GEN_W-1:0]     result_generation,
	output logic                          handle_valid,
	output logic                          table_full,
	output logic                          rejected,
	output logic [gha_pkg::IDX_W-1:0]     live_count
);

	import gha_pkg::*;

	op_t                op_q;
	logic [IDX_W-1:0]   idx_q;
	logic [GEN_W-1:0]   gen_q;
	logic [IDX_W-1:0]   used_q, used_d;
	logic [IDX_W-1:0]   head_q, head_d;
	logic [IDX_W-1:0]   live_q, live_d;
	logic [SLOT_AW-1:0] cnt_q;
	logic [IDX_W-1:0]   cnt_ext;

	logic               done_q, done_d;
	logic [IDX_W-1:0]   ridx_q, ridx_d;
	logic [GEN_W-1:0]   rgen_q, rgen_d;
	logic               valid_q, valid_d;
	logic               full_q, full_d;
	logic               rej_q, rej_d;

	logic               head_ok;
	logic               in_range;
	logic               live_hit;
	logic [GEN_W-1:0]   gen_bumped;

	assign head_ok    = (head_q != '0) && (head_q <= used_q);
	assign in_range   = (idx_q != '0) && (idx_q <= used_q);
	assign live_hit   = in_range && !ram_rdata.empty && (ram_rdata.gen == gen_q);
	assign gen_bumped = bump_gen(ram_rdata.gen);
	assign cnt_ext    = {1'b0, cnt_q};

	assign stat.sweep_go   = (op_q == OP_CLEAR) && (used_q != '0);
	assign stat.sweep_last = (cnt_ext + IDX_W'(1)) == used_q;

	// read port: free-list head, word's slot, or first/next sweep entry
	always_comb begin
		logic [IDX_W-1:0] ra;
		ra = '0;
		if (cmd.accept) begin
			case (op_t'(operation))
				OP_ALLOC:  ra = head_q - IDX_W'(1);
				OP_CLEAR:  ra = '0;
				default:   ra = handle_index - IDX_W'(1);
			endcase
		end else if (cmd.sweep) begin
			ra = cnt_ext + IDX_W'(1);
		end
		ram_re    = cmd.accept || cmd.sweep;
		ram_raddr = ra[SLOT_AW-1:0];
	end

	always_comb begin
		logic [IDX_W-1:0] wa;
		wa        = '0;
		ram_we    = 1'b0;
		ram_wdata = '0;
		used_d    = used_q;
		head_d    = head_q;
		live_d    = live_q;
		done_d    = 1'b0;
		ridx_d    = '0;
		rgen_d    = '0;
		valid_d   = 1'b0;
		full_d    = 1'b0;
		rej_d     = 1'b0;

		if (cmd.exec) begin
			case (op_q)
				OP_ALLOC: begin
					done_d = 1'b1;
					if (head_ok) begin
						ram_we    = 1'b1;
						wa        = head_q - IDX_W'(1);
						ram_wdata = '{empty: 1'b0, next: '0, gen: gen_bumped};
						head_d    = ram_rdata.next;
						live_d    = live_q + IDX_W'(1);
						ridx_d    = head_q;
						rgen_d    = gen_bumped;
					end else if (used_q == IDX_W'(MAX_SLOTS)) begin
						full_d = 1'b1;
					end else begin
						ram_we    = 1'b1;
						wa        = used_q;
						ram_wdata = '{empty: 1'b0, next: '0, gen: GEN_W'(1)};
						used_d    = used_q + IDX_W'(1);
						live_d    = live_q + IDX_W'(1);
						ridx_d    = used_q + IDX_W'(1);
						rgen_d    = GEN_W'(1);
					end
				end
				OP_CHECK: begin
					done_d  = 1'b1;
					valid_d = live_hit;
				end
				OP_REMOVE: begin
					done_d = 1'b1;
					if (live_hit) begin
						ram_we    = 1'b1;
						wa        = idx_q - IDX_W'(1);
						ram_wdata = '{empty: 1'b1, next: head_q, gen: ram_rdata.gen};
						head_d    = idx_q;
						live_d    = live_q - IDX_W'(1);
						valid_d   = 1'b1;
					end else begin
						rej_d = 1'b1;
					end
				end
				OP_CLEAR: begin
					done_d = !stat.sweep_go;
				end
				default: begin
					done_d = 1'b1;
				end
			endcase
		end else if (cmd.sweep) begin
			ram_we    = 1'b1;
			wa        = cnt_ext;
			ram_wdata = '{empty: 1'b1,
			              next:  stat.sweep_last ? '0 : cnt_ext + IDX_W'(2),
			              gen:   gen_bumped};
			if (stat.sweep_last) begin
				head_d = IDX_W'(1);
				live_d = '0;
				done_d = 1'b1;
			end
		end
		ram_waddr = wa[SLOT_AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			head_q <= '0;
			live_q <= '0;
			done_q <= 1'b0;
		end else begin
			used_q <= used_d;
			head_q <= head_d;
			live_q <= live_d;
			done_q <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= op_t'(operation);
			idx_q <= handle_index;
			gen_q <= handle_generation;
		end
		if (cmd.exec) begin
			cnt_q <= '0;
		end else if (cmd.sweep) begin
			cnt_q <= cnt_q + SLOT_AW'(1);
		end
		if (done_d) begin
			ridx_q  <= ridx_d;
			rgen_q  <= rgen_d;
			valid_q <= valid_d;
			full_q  <= full_d;
			rej_q   <= rej_d;
		end
	end

	assign done              = done_q;
	assign result_index      = ridx_q;
	assign result_generation = rgen_q;
	assign handle_valid      = valid_q;
	assign table_full        = full_q;
	assign rejected          = rej_q;
	assign live_count        = live_q;

	`ASSERT_PROP(a_live_le_used, clk, arst_n, live_q <= used_q, "live count above high-water mark")
	`ASSERT_NEVER(a_used_max, clk, arst_n, used_q > IDX_W'(MAX_SLOTS), "high-water mark overflow")
	`ASSERT_PROP(a_remove_push, clk, arst_n,
		(cmd.exec && op_q == OP_REMOVE && live_hit) |=> (head_q == $past(idx_q)),
		"removed slot not at free-list head")
	`ASSERT_PROP(a_done_single, clk, arst_n, done_q |=> !done_q, "result strobe held over")

endmodule

// ===== design/generational_handle_allocator_core.sv =====
// Allocate, check and remove: the word is taken and its slot read in idle, updated in the
// execute state, and done is strobed from a register; a new word is taken only in idle.
// Clear walks the used slots, one RAM entry a cycle, then strobes done.
// Reset clears the high-water mark, free-list head and live count; the slot RAM
// holds no reset and needs no clearing pass. The receiver cannot stall.
// -----------------------------------------------------------------------------
// generational_handle_allocator_core
// Generational handle allocator with a free list threaded through slot RAM.
// -----------------------------------------------------------------------------
module generational_handle_allocator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    operation,
	input  logic [gha_pkg::IDX_W-1:0]     handle_index,
	input  logic [gha_pkg::GEN_W-1:0]     handle_generation,
	output logic                          done,
	output logic [gha_pkg::IDX_W-1:0]     result_index,
	output logic [gha_pkg::GEN_W-1:0]     result_generation,
	output logic                          handle_valid,
	output logic                          table_full,
	output logic                          rejected,
	output logic [gha_pkg::IDX_W-1:0]     live_count
);

	import gha_pkg::*;

	cmd_t               cmd;
	stat_t              stat;
	logic               ram_we;
	logic [SLOT_AW-1:0] ram_waddr;
	slot_t              ram_wdata;
	logic               ram_re;
	logic [SLOT_AW-1:0] ram_raddr;
	slot_t              ram_rdata;

	gha_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	gha_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.operation         (operation),
		.handle_index      (handle_index),
		.handle_generation (handle_generation),
		.ram_we            (ram_we),
		.ram_waddr         (ram_waddr),
		.ram_wdata         (ram_wdata),
		.ram_re            (ram_re),
		.ram_raddr         (ram_raddr),
		.ram_rdata         (ram_rdata),
		.done              (done),
		.result_index      (result_index),
		.result_generation (result_generation),
		.handle_valid      (handle_valid),
		.table_full        (table_full),
		.rejected          (rejected),
		.live_count        (live_count)
	);

	gha_ram #(
		.WIDTH ($bits(slot_t)),
		.DEPTH (MAX_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb
// Drives allocate, check, remove and clear words into the handle allocator and
// scores every reply against a predicted slot table. Covers the null handle,
// out-of-range and stale handles, free-list reuse and clears.
// -----------------------------------------------------------------------------
module tb;
	import gha_pkg::*;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic [GEN_W-1:0] generation;
		logic             valid;
		logic             full;
		logic             rejected;
		logic [IDX_W-1:0] live;
	} reply_t;

	class handle_table_model;
		logic [GEN_W-1:0] gen_of [MAX_SLOTS];
		bit               is_free [MAX_SLOTS];
		int unsigned      link_of [MAX_SLOTS];
		int unsigned      used, head, live;
		reply_t           pending [$];
		int unsigned      errors, replies, n_full, n_reject, n_wrap;
		int unsigned      op_seen [4];

		function logic [GEN_W-1:0] advance(logic [GEN_W-1:0] g);
			logic [GEN_W-1:0] n;
			n = g + GEN_W'(1);
			if (n == '0) begin
				n_wrap++;
				n = GEN_W'(1);
			end
			return n;
		endfunction

		function bit holds(int unsigned idx, logic [GEN_W-1:0] g);
			if (idx == 0 || idx > used)
				return 1'b0;
			return !is_free[idx-1] && gen_of[idx-1] == g;
		endfunction

		function void accept_word(op_t op, logic [IDX_W-1:0] idx, logic [GEN_W-1:0] g);
			reply_t      r;
			int unsigned s;
			int unsigned i;
			r = '0;
			op_seen[int'(op)]++;
			case (op)
			OP_ALLOC: begin
				if (head != 0 && head <= used) begin
					s = head - 1;
					gen_of[s] = advance(gen_of[s]);
					head = link_of[s];
					is_free[s] = 1'b0;
					link_of[s] = 0;
					live++;
					r.index = IDX_W'(s + 1);
					r.generation = gen_of[s];
				end else if (used >= MAX_SLOTS) begin
					r.full = 1'b1;
					n_full++;
				end else begin
					gen_of[used] = GEN_W'(1);
					is_free[used] = 1'b0;
					link_of[used] = 0;
					used++;
					live++;
					r.index = IDX_W'(used);
					r.generation = GEN_W'(1);
				end
			end
			OP_CHECK: begin
				r.valid = holds(32'(idx), g);
			end
			OP_REMOVE: begin
				if (holds(32'(idx), g)) begin
					is_free[idx-1] = 1'b1;
					link_of[idx-1] = head;
					head = 32'(idx);
					live--;
					r.valid = 1'b1;
				end else begin
					r.rejected = 1'b1;
					n_reject++;
				end
			end
			default: begin
				if (used != 0) begin
					for (i = 0; i < used; i++) begin
						gen_of[i] = advance(gen_of[i]);
						is_free[i] = 1'b1;
						link_of[i] = (i + 1 < used) ? i + 2 : 0;
					end
					head = 1;
					live = 0;
				end
			end
			endcase
			r.live = IDX_W'(live);
			pending = {pending, r};
		endfunction

		function void field_ok(string name, logic [31:0] want_v, logic [31:0] got_v);
			if (got_v !== want_v) begin
				$error("%s: expected %0d, got %0d", name, want_v, got_v);
				errors++;
			end
		endfunction

		function void check_reply(reply_t got);
			reply_t want;
			if (pending.size() == 0) begin
				$error("reply with nothing outstanding");
				errors++;
				return;
			end
			want = pending.pop_front();
			replies++;
			field_ok("result_index", 32'(want.index), 32'(got.index));
			field_ok("result_generation", 32'(want.generation), 32'(got.generation));
			field_ok("handle_valid", 32'(want.valid), 32'(got.valid));
			field_ok("table_full", 32'(want.full), 32'(got.full));
			field_ok("rejected", 32'(want.rejected), 32'(got.rejected));
			field_ok("live_count", 32'(want.live), 32'(got.live));
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [1:0]       operation;
	logic [IDX_W-1:0] handle_index;
	logic [GEN_W-1:0] handle_generation;
	logic             done;
	logic [IDX_W-1:0] result_index;
	logic [GEN_W-1:0] result_generation;
	logic             handle_valid;
	logic             table_full;
	logic             rejected;
	logic [IDX_W-1:0] live_count;

	handle_table_model tables;
	bit                gaps_on;

	generational_handle_allocator_core dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.operation         (operation),
		.handle_index      (handle_index),
		.handle_generation (handle_generation),
		.done              (done),
		.result_index      (result_index),
		.result_generation (result_generation),
		.handle_valid      (handle_valid),
		.table_full        (table_full),
		.rejected          (rejected),
		.live_count        (live_count)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && start && !busy)
			tables.accept_word(op_t'(operation), handle_index, handle_generation);
	end

	always @(posedge clk) begin
		if (arst_n && done)
			tables.check_reply({result_index, result_generation, handle_valid, table_full,
				rejected, live_count});
	end

	task automatic send_word(op_t op, logic [IDX_W-1:0] idx, logic [GEN_W-1:0] g);
		int unsigned n;
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 16);
			start <= 1'b0;
			repeat (n) @(negedge clk);
		end
		start <= 1'b1;
		operation <= op;
		handle_index <= idx;
		handle_generation <= g;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic random_word(int unsigned clear_pct);
		op_t              op;
		logic [IDX_W-1:0] idx;
		logic [GEN_W-1:0] g;
		int unsigned      pick;
		int unsigned      k;
		int unsigned      tries;
		idx = IDX_W'($urandom_range(0, 2047));
		g = GEN_W'($urandom_range(0, 65535));
		pick = $urandom_range(0, 99);
		if (pick < clear_pct)
			op = OP_CLEAR;
		else if (pick < 40)
			op = OP_ALLOC;
		else if (pick < 65)
			op = OP_CHECK;
		else
			op = OP_REMOVE;
		if ((op == OP_CHECK || op == OP_REMOVE) && tables.used != 0) begin
			k = $urandom_range(0, 9);
			if (k < 7) begin
				idx = IDX_W'($urandom_range(1, tables.used));
				for (tries = 0; tries < 4 && tables.is_free[idx-1]; tries++)
					idx = IDX_W'($urandom_range(1, tables.used));
				g = tables.gen_of[idx-1];
				if (k == 6)
					g = g ^ GEN_W'($urandom_range(1, 65535));
			end else if (k == 7) begin
				idx = '0;
			end else if (k == 8) begin
				idx = IDX_W'(tables.used + $urandom_range(1, 3));
				g = GEN_W'(1);
			end
		end
		send_word(op, idx, g);
	endtask

	initial begin
		int unsigned n;
		tables = new();
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_ALLOC;
		handle_index = '0;
		handle_generation = '0;
		gaps_on = 1'b1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table, null and out-of-range handles
		send_word(OP_CLEAR, 11'd2047, 16'hFFFF);
		send_word(OP_CHECK, '0, '0);
		send_word(OP_REMOVE, 11'd1, 16'd1);
		send_word(OP_ALLOC, 11'd2047, 16'hFFFF);
		send_word(OP_ALLOC, '0, '0);
		send_word(OP_CHECK, 11'd1, 16'd1);
		send_word(OP_CHECK, 11'd1, 16'h8001);
		send_word(OP_CHECK, 11'd3, 16'd1);
		send_word(OP_CHECK, 11'd2047, 16'hFFFF);
		send_word(OP_REMOVE, 11'd2, 16'd1);
		send_word(OP_REMOVE, 11'd2, 16'd1);
		send_word(OP_CHECK, 11'd2, 16'd1);
		send_word(OP_ALLOC, '0, '0);
		send_word(OP_CLEAR, '0, '0);

		// stale generations after clear, reuse through the free list
		send_word(OP_ALLOC, '0, '0);
		send_word(OP_CHECK, 11'd1, 16'hFFFF);
		send_word(OP_CHECK, 11'd1, 16'h0000);
		send_word(OP_REMOVE, 11'd1, 16'hFFFF);
		send_word(OP_ALLOC, '0, '0);
		send_word(OP_CLEAR, '0, '0);
		send_word(OP_ALLOC, '0, '0);
		send_word(OP_ALLOC, '0, '0);
		send_word(OP_REMOVE, 11'd1, tables.gen_of[0]);
		send_word(OP_REMOVE, 11'd2, tables.gen_of[1]);
		send_word(OP_ALLOC, '0, '0);

		repeat (270)
			random_word(3);

		// top of the index range
		send_word(OP_CHECK, IDX_W'(MAX_SLOTS), 16'd1);
		send_word(OP_CHECK, IDX_W'(MAX_SLOTS + 1), 16'd1);
		send_word(OP_CHECK, 11'd2047, 16'hFFFF);
		send_word(OP_REMOVE, IDX_W'(MAX_SLOTS), 16'd1);
		send_word(OP_ALLOC, '0, '0);
		send_word(OP_ALLOC, '0, '0);

		repeat (200)
			random_word(2);
		gaps_on = 1'b0;
		repeat (150)
			random_word(2);
		start <= 1'b0;

		for (n = 0; n < 10000 && tables.pending.size() != 0; n++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (tables.pending.size() != 0) begin
			$error("%0d replies never arrived", tables.pending.size());
			tables.errors++;
		end

		$display("%0d replies scored: %0d allocate (%0d full), %0d check",
			tables.replies, tables.op_seen[0], tables.n_full, tables.op_seen[1]);
		$display("%0d remove (%0d rejected), %0d clear, %0d wraps, %0d slots touched",
			tables.op_seen[2], tables.n_reject, tables.op_seen[3], tables.n_wrap,
			tables.used);
		if (tables.errors == 0)
			$display("generational_handle_allocator_core: match");
		else
			$display("generational_handle_allocator_core: mismatch");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("generational_handle_allocator_core: mismatch");
		$finish;
	end

endmodule
